@@ hdl/rau_pkg.sv @@
`timescale 1ns / 1ps
package rau_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int OP_SHIFT      = 32 - OPERAND_WIDTH;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_RED = 3'd4
	} cmd_t;

	typedef struct packed {
		logic load;
		logic mul0;
		logic mul1;
		logic mul2;
		logic comb;
		logic check;
		logic gcd_step;
		logic gcd_fin;
		logic div_step;
		logic div_swap;
		logic fin;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_red;
		logic is_addsub;
		logic special;
		logic gcd_done;
	} dp_stat_t;

	function automatic logic signed [31:0] sext_op(input logic [31:0] v);
		logic [31:0] sh;
		sh = v << OP_SHIFT;
		return $signed(sh) >>> OP_SHIFT;
	endfunction

endpackage

@@ hdl/rational_arith_unit.sv @@
`timescale 1ns / 1ps
// a zero numerator or denominator skips the gcd and both divisions and goes from CHECK
// straight to DONE
// operands are combined on one 32x32 multiplier (MUL0, MUL1, MUL2, COMB), then a binary gcd
// of subtract-and-shift steps, then two 64-step restoring divisions
// one item at a time; the next beat is taken once the result sits in the output register
// reset: arst_n clears the controller state and the output valid flag, no clearing pass
module rational_arith_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
	input  logic [2:0]   s_axis_tuser,  // cmd
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // res_num, res_den
	output logic [0:0]   m_axis_tuser   // status
);
	import rau_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  st;
	logic      err;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (st),
		.cmd       (ctl)
	);

	rau_dp u_dp (
		.clk      (clk),
		.cmd      (ctl),
		.stat     (st),
		.in_cmd   (s_axis_tuser),
		.in_data  (s_axis_tdata),
		.out_data (m_axis_tdata),
		.out_err  (err)
	);

	assign m_axis_tuser = err;

	a_err_den_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[127:64] == 64'd0)
		else $error("error result with nonzero denominator");

	a_ok_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
			m_axis_tdata[127:64] != 64'd0 && !m_axis_tdata[127])
		else $error("denominator not positive");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("beat accepted while busy");

endmodule

@@ hdl/rau_ctrl.sv @@
`timescale 1ns / 1ps
module rau_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  rau_pkg::dp_stat_t  stat,
	output rau_pkg::ctrl_cmd_t cmd
);
	import rau_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_MUL0  = 12'b000000000010,
		ST_MUL1  = 12'b000000000100,
		ST_MUL2  = 12'b000000001000,
		ST_COMB  = 12'b000000010000,
		ST_CHECK = 12'b000000100000,
		ST_GCD   = 12'b000001000000,
		ST_DIVN  = 12'b000010000000,
		ST_DSWP  = 12'b000100000000,
		ST_DIVD  = 12'b001000000000,
		ST_FIN   = 12'b010000000000,
		ST_DONE  = 12'b100000000000
	} state_t;

	state_t     state_q, state_d;
	logic [5:0] cnt_q;
	logic       out_valid_q;
	logic       can_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign can_load  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL0;
				end
			end
			ST_MUL0: begin
				cmd.mul0 = 1'b1;
				state_d  = stat.is_red ? ST_CHECK : ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = stat.is_addsub ? ST_MUL2 : ST_CHECK;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_COMB;
			end
			ST_COMB: begin
				cmd.comb = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = stat.special ? ST_DONE : ST_GCD;
			end
			ST_GCD: begin
				if (stat.gcd_done) begin
					cmd.gcd_fin = 1'b1;
					state_d     = ST_DIVN;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIVN: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '1) begin
					state_d = ST_DSWP;
				end
			end
			ST_DSWP: begin
				cmd.div_swap = 1'b1;
				state_d      = ST_DIVD;
			end
			ST_DIVD: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '1) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (can_load) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) begin
				cnt_q <= cnt_q + 6'd1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/rau_dp.sv @@
`timescale 1ns / 1ps
module rau_dp (
	input  logic               clk,
	input  rau_pkg::ctrl_cmd_t cmd,
	output rau_pkg::dp_stat_t  stat,
	input  logic [2:0]         in_cmd,
	input  logic [127:0]       in_data,
	output logic [127:0]       out_data,
	output logic               out_err
);
	import rau_pkg::*;

	logic [2:0]         cmd_q;
	logic signed [31:0] an_q, ad_q, bn_q, bd_q;
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic [63:0]        rn_q, rd_q, p_q;
	logic [63:0]        gx_q, gy_q, mn_q, md_q, g_q;
	logic [5:0]         k_q;
	logic               neg_q;
	logic [63:0]        rem_q, dq_q, qn_q;
	logic [64:0]        trial, diff;
	logic [63:0]        res_num_q, res_den_q;
	logic               res_err_q;
	logic               addsub;

	assign addsub = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB);

	assign stat.is_red    = !addsub && (cmd_q != CMD_MUL) && (cmd_q != CMD_DIV);
	assign stat.is_addsub = addsub;
	assign stat.special   = (rd_q == '0) || (rn_q == '0);
	assign stat.gcd_done  = (gx_q == gy_q);

	always_comb begin
		ma = an_q;
		mb = bd_q;
		if (cmd.mul0) begin
			ma = an_q;
			mb = (cmd_q == CMD_MUL) ? bn_q : bd_q;
		end else if (cmd.mul1) begin
			ma = ad_q;
			mb = (cmd_q == CMD_DIV) ? bn_q : bd_q;
		end else begin
			ma = bn_q;
			mb = ad_q;
		end
	end

	assign prod  = ma * mb;
	assign trial = {rem_q, dq_q[63]};
	assign diff  = trial - {1'b0, g_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd;
			an_q  <= sext_op(in_data[31:0]);
			ad_q  <= sext_op(in_data[63:32]);
			bn_q  <= sext_op(in_data[95:64]);
			bd_q  <= sext_op(in_data[127:96]);
		end
		if (cmd.mul0) begin
			if (stat.is_red) begin
				rn_q <= 64'(an_q);
				rd_q <= 64'(ad_q);
			end else begin
				rn_q <= prod;
			end
		end
		if (cmd.mul1) begin
			rd_q <= prod;
		end
		if (cmd.mul2) begin
			p_q <= prod;
		end
		if (cmd.comb) begin
			rn_q <= (cmd_q == CMD_SUB) ? rn_q - p_q : rn_q + p_q;
		end
		if (cmd.check) begin
			neg_q <= rn_q[63] ^ rd_q[63];
			gx_q  <= rn_q[63] ? -rn_q : rn_q;
			gy_q  <= rd_q[63] ? -rd_q : rd_q;
			mn_q  <= rn_q[63] ? -rn_q : rn_q;
			md_q  <= rd_q[63] ? -rd_q : rd_q;
			k_q   <= '0;
			if (rd_q == '0) begin
				res_num_q <= rn_q;
				res_den_q <= '0;
				res_err_q <= 1'b1;
			end else begin
				res_num_q <= '0;
				res_den_q <= 64'd1;
				res_err_q <= 1'b0;
			end
		end
		if (cmd.gcd_step) begin
			if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1;
				gy_q <= gy_q >> 1;
				k_q  <= k_q + 6'd1;
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else if (gx_q > gy_q) begin
				gx_q <= (gx_q - gy_q) >> 1;
			end else begin
				gy_q <= (gy_q - gx_q) >> 1;
			end
		end
		if (cmd.gcd_fin) begin
			g_q   <= gx_q << k_q;
			dq_q  <= mn_q;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			if (!diff[64]) begin
				rem_q <= diff[63:0];
				dq_q  <= {dq_q[62:0], 1'b1};
			end else begin
				rem_q <= trial[63:0];
				dq_q  <= {dq_q[62:0], 1'b0};
			end
		end
		if (cmd.div_swap) begin
			qn_q  <= dq_q;
			dq_q  <= md_q;
			rem_q <= '0;
		end
		if (cmd.fin) begin
			res_num_q <= neg_q ? -qn_q : qn_q;
			res_den_q <= dq_q;
			res_err_q <= 1'b0;
		end
		if (cmd.out_load) begin
			out_data <= {res_den_q, res_num_q};
			out_err  <= res_err_q;
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import rau_pkg::*;

	typedef struct packed {
		logic [63:0] num;
		logic [63:0] den;
		logic        status;
	} frac_res_t;

	class frac_scoreboard;
		frac_res_t pending[$];
		int        errors;

		function logic [63:0] widen(logic [31:0] v);
			logic signed [31:0] s;
			s = sext_op(v);
			return {{32{s[31]}}, s};
		endfunction

		function logic [63:0] mag(logic [63:0] v);
			return v[63] ? 64'd0 - v : v;
		endfunction

		function logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
			logic [63:0] r;
			while (y != 0) begin
				r = x % y;
				x = y;
				y = r;
			end
			return x;
		endfunction

		function frac_res_t reduce_frac(logic [2:0] cmd, logic [127:0] d);
			logic [63:0] an, ad, bn, bd, rn, rd, g, qn;
			frac_res_t r;
			an = widen(d[31:0]);
			ad = widen(d[63:32]);
			bn = widen(d[95:64]);
			bd = widen(d[127:96]);
			case (cmd)
				CMD_ADD: begin rn = an * bd + bn * ad; rd = ad * bd; end
				CMD_SUB: begin rn = an * bd - bn * ad; rd = ad * bd; end
				CMD_MUL: begin rn = an * bn; rd = ad * bd; end
				CMD_DIV: begin rn = an * bd; rd = ad * bn; end
				default: begin rn = an; rd = ad; end
			endcase
			if (rd == 0) begin
				r.num = rn; r.den = 64'd0; r.status = 1'b1;
			end else if (rn == 0) begin
				r.num = 64'd0; r.den = 64'd1; r.status = 1'b0;
			end else begin
				g = euclid(mag(rn), mag(rd));
				qn = mag(rn) / g;
				r.num = (rn[63] ^ rd[63]) ? 64'd0 - qn : qn;
				r.den = mag(rd) / g;
				r.status = 1'b0;
			end
			return r;
		endfunction

		function void note_request(logic [2:0] cmd, logic [127:0] d);
			pending.push_back(reduce_frac(cmd, d));
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_result(logic [127:0] d, logic st);
			frac_res_t e;
			if (pending.size() == 0) begin
				report("unexpected beat", d[63:0], 64'd0);
				return;
			end
			e = pending.pop_front();
			if (d[63:0] !== e.num) report("res_num", d[63:0], e.num);
			if (d[127:64] !== e.den) report("res_den", d[127:64], e.den);
			if (st !== e.status) report("status", 64'(st), 64'(e.status));
		endtask
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [2:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [127:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	frac_scoreboard sb = new();
	int phase = 0;
	int cycles = 0;

	rational_arith_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		case (phase)
			0: m_axis_tready <= ($urandom_range(99) >= 67);
			1: m_axis_tready <= ($urandom_range(99) >= 25);
			default: m_axis_tready <= 1'b1;
		endcase
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser[0]);
	end

	function logic [31:0] pick_operand();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hffff_ffff;
			3: return 32'h7fff_ffff;
			4: return 32'h8000_0001;
			5: return 32'h8000_0000;
			6: return $urandom;
			7: return $urandom_range(12) * $urandom_range(1, 360);
			8: return 32'd0 - $urandom_range(1, 5000);
			default: return $urandom_range(0, 100000) * 6;
		endcase
	endfunction

	task send_frac(logic [2:0] cmd, logic [31:0] an, logic [31:0] ad,
	               logic [31:0] bn, logic [31:0] bd);
		if (phase == 0) begin
			while ($urandom_range(99) < 25) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end else if (phase == 1) begin
			while ($urandom_range(99) < 67) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {bd, bn, ad, an};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(cmd, {bd, bn, ad, an});
	endtask

	initial begin
		logic [2:0] c;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, each command, zero denominators and numerators
		send_frac(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		send_frac(CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
		send_frac(CMD_MUL, 32'd6, 32'hffff_fff8, 32'd4, 32'd9);
		send_frac(CMD_DIV, 32'd3, 32'd4, 32'hffff_fffe, 32'd5);
		send_frac(CMD_RED, 32'd84, 32'hffff_ffb8, 32'd0, 32'd0);
		send_frac(CMD_RED, 32'd0, 32'd0, 32'd0, 32'd0);
		send_frac(CMD_RED, 32'd0, 32'd7, 32'd0, 32'd0);
		send_frac(CMD_DIV, 32'd5, 32'd3, 32'd0, 32'd9);
		send_frac(CMD_ADD, 32'd5, 32'd0, 32'd1, 32'd1);
		send_frac(CMD_MUL, 32'd0, 32'd3, 32'd7, 32'd11);
		send_frac(CMD_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_frac(CMD_SUB, 32'h8000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001);
		send_frac(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_frac(CMD_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
		send_frac(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1);
		send_frac(CMD_DIV, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'd1);
		send_frac(3'd5, 32'd10, 32'd4, 32'd1, 32'd1);
		send_frac(3'd6, 32'hffff_fff6, 32'hffff_fffc, 32'd1, 32'd1);
		send_frac(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_frac(CMD_RED, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0);
		for (int i = 0; i < 450; i++) begin
			if (i == 150) phase = 1;
			if (i == 300) phase = 2;
			c = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
			send_frac(c, pick_operand(), pick_operand(), pick_operand(), pick_operand());
		end
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
